>>> rtl/max_min_fair_rate_allocator_macros.svh
// ----------------------------------------------------------------------------
// Max-min fair rate allocator assertion macros
// Concurrent assertion shorthands clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef MAX_MIN_FAIR_RATE_ALLOCATOR_MACROS_SVH
`define MAX_MIN_FAIR_RATE_ALLOCATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MMFRA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MMFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mmfra_pkg.sv
// ----------------------------------------------------------------------------
// Max-min fair rate allocator package
// Fixed field widths, stream packing and register map constants.
// ----------------------------------------------------------------------------
package mmfra_pkg;

  // field widths of the stream items
  localparam int SLOT_W      = 4;
  localparam int RATE_W      = 40;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - SLOT_W - RATE_W;

  // input tdata bit positions
  localparam int IN_USE_BIT   = SLOT_W;
  localparam int IN_GRANT_LSB = SLOT_W + 1;
  localparam int IN_ELIG_BIT  = IN_GRANT_LSB + RATE_W;
  localparam int IN_REP_BIT   = IN_ELIG_BIT + 1;
  localparam int IN_FRESH_BIT = IN_REP_BIT + 1;

  // register port
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_LINK_CAP = 1'b0;

  localparam logic [63:0] LINK_CAP_RESET = 64'd100000000000;

endpackage

>>> rtl/mmfra_div.sv
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Divides a wide dividend by a narrow nonzero divisor, one quotient bit per
// cycle; done_o pulses for one cycle with the quotient on quot_o.
// ----------------------------------------------------------------------------
module mmfra_div #(
  parameter int DIVIDEND_W = 40,
  parameter int DIVISOR_W  = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic                  fits;

  // one restoring step
  assign trial     = {rem_q, quo_q[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign fits      = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DIVIDEND_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d  = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d  = {quo_q[DIVIDEND_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/max_min_fair_rate_allocator.sv
// ----------------------------------------------------------------------------
// Max-min fair rate allocator
// Flow slot table with progressive filling of link capacity over the active
// slots; every update reports the effective rate of all slots in order.
// ----------------------------------------------------------------------------
// channel   | direction | contents
// s_axis    | in        | one slot rewrite per transfer
// m_axis    | out       | FLOW_SLOTS rate reports per input, tlast on the final slot
// apb       | config    | link_capacity at byte address 0
//
// each input runs up to FLOW_SLOTS rounds of divide and slot walk
// s_axis_tready is high only between inputs
// reset clears the slot table flags and loads the default link capacity
// output stalls hold the report walk; the last report may still wait while
// the next input is taken
// ----------------------------------------------------------------------------
`include "max_min_fair_rate_allocator_macros.svh"

module max_min_fair_rate_allocator #(
  parameter int FLOW_SLOTS = 16,
  parameter int RATE_BITS  = 40
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave stream: [3:0] flow_slot, [4] slot_in_use, [44:5] grant_rate,
  // [45] eligible flag, [46] repair_pending, [47] fresh_payload_left
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mmfra_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // master stream: [3:0] out_slot, [43:4] effective_rate, [47:44] zero
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mmfra_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                                m_axis_tlast,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mmfra_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mmfra_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mmfra_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);

  localparam int IDX_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int CNT_W = $clog2(FLOW_SLOTS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_ROUND  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_SPREAD = 3'd5;
  localparam logic [2:0] S_REPORT = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [RATE_BITS-1:0]  alloc_q, alloc_d;
  logic [RATE_BITS-1:0]  share_q, share_d;
  logic                  froze_q, froze_d;
  logic [RATE_BITS-1:0]  cap_q;
  logic [FLOW_SLOTS-1:0] live_q, live_d;
  logic [FLOW_SLOTS-1:0] valid_q, elig_q, rep_q, fresh_q;
  logic [RATE_BITS-1:0]  grant_q [FLOW_SLOTS];
  logic [RATE_BITS-1:0]  rate_q  [FLOW_SLOTS];

  logic                  out_valid_q;
  logic [mmfra_pkg::SLOT_W-1:0] out_slot_q;
  logic [mmfra_pkg::RATE_W-1:0] out_rate_q;
  logic                  out_last_q;

  logic                  in_fire;
  logic [mmfra_pkg::SLOT_W-1:0] in_slot;
  logic [RATE_BITS-1:0]  in_grant;
  logic                  slot_ok;
  logic [IDX_W-1:0]      wr_idx;
  logic                  idx_last;
  logic                  live_calc;
  logic                  fits_share;
  logic                  rate_we;
  logic [RATE_BITS-1:0]  rate_wdata;
  logic                  out_load;
  logic                  div_start;
  logic                  div_done;
  logic [RATE_BITS-1:0]  div_quot;
  logic                  cfg_we;
  logic                  cfg_sel;

  // input field unpacking
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign in_slot  = s_axis_tdata[mmfra_pkg::SLOT_W-1:0];
  assign in_grant = RATE_BITS'(s_axis_tdata[mmfra_pkg::IN_GRANT_LSB +: mmfra_pkg::RATE_W]);
  assign slot_ok  = 32'(in_slot) < 32'(FLOW_SLOTS);
  assign wr_idx   = IDX_W'(in_slot);

  // per-slot views at the walk index
  assign idx_last   = (idx_q == IDX_W'(FLOW_SLOTS - 1));
  assign live_calc  = valid_q[idx_q] && elig_q[idx_q] && (fresh_q[idx_q] || rep_q[idx_q])
                      && (grant_q[idx_q] != '0);
  assign fits_share = live_q[idx_q] && (grant_q[idx_q] <= share_q);

  // filling sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    alloc_d    = alloc_q;
    share_d    = share_q;
    froze_d    = froze_q;
    live_d     = live_q;
    rate_we    = 1'b0;
    rate_wdata = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cnt_d   = '0;
          alloc_d = '0;
          idx_d   = '0;
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        rate_we       = 1'b1;
        live_d[idx_q] = live_calc;
        cnt_d         = cnt_q + CNT_W'(live_calc);
        if (idx_last) begin
          idx_d   = '0;
          state_d = S_ROUND;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_ROUND: begin
        if ((cnt_q == '0) || (alloc_q >= cap_q)) begin
          idx_d   = '0;
          state_d = S_REPORT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          share_d = div_quot;
          froze_d = 1'b0;
          idx_d   = '0;
          state_d = (div_quot == '0) ? S_REPORT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (fits_share) begin
          alloc_d       = alloc_q + grant_q[idx_q];
          rate_we       = 1'b1;
          rate_wdata    = grant_q[idx_q];
          live_d[idx_q] = 1'b0;
          cnt_d         = cnt_q - CNT_W'(1);
          froze_d       = 1'b1;
        end
        if (idx_last) begin
          idx_d   = '0;
          state_d = (froze_q || fits_share) ? S_ROUND : S_SPREAD;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_SPREAD: begin
        if (live_q[idx_q]) begin
          rate_we    = 1'b1;
          rate_wdata = share_q;
        end
        if (idx_last) begin
          idx_d   = '0;
          state_d = S_REPORT;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_REPORT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          if (idx_last) begin
            idx_d   = '0;
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // shared share divider
  mmfra_div #(
    .DIVIDEND_W (RATE_BITS),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cap_q - alloc_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // control state and slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      alloc_q <= '0;
      share_q <= '0;
      froze_q <= 1'b0;
      live_q  <= '0;
      valid_q <= '0;
      elig_q  <= '0;
      rep_q   <= '0;
      fresh_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      alloc_q <= alloc_d;
      share_q <= share_d;
      froze_q <= froze_d;
      live_q  <= live_d;
      if (in_fire && slot_ok) begin
        valid_q[wr_idx] <= s_axis_tdata[mmfra_pkg::IN_USE_BIT];
        elig_q[wr_idx]  <= s_axis_tdata[mmfra_pkg::IN_ELIG_BIT];
        rep_q[wr_idx]   <= s_axis_tdata[mmfra_pkg::IN_REP_BIT];
        fresh_q[wr_idx] <= s_axis_tdata[mmfra_pkg::IN_FRESH_BIT];
      end
    end
  end

  // grant and rate tables
  always_ff @(posedge clk_i) begin
    if (in_fire && slot_ok) begin
      grant_q[wr_idx] <= in_grant;
    end
    if (rate_we) begin
      rate_q[idx_q] <= rate_wdata;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_slot_q <= mmfra_pkg::SLOT_W'(idx_q);
      out_rate_q <= mmfra_pkg::RATE_W'(rate_q[idx_q]);
      out_last_q <= idx_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{mmfra_pkg::OUT_PAD_W{1'b0}}, out_rate_q, out_slot_q};
  assign m_axis_tlast  = out_last_q;

  // register port
  assign cfg_sel = (paddr[mmfra_pkg::APB_ADDR_W-1 -: mmfra_pkg::REG_IDX_W]
                    == mmfra_pkg::REG_LINK_CAP);
  assign cfg_we  = psel && penable && pwrite && cfg_sel;
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? mmfra_pkg::APB_DATA_W'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= RATE_BITS'(mmfra_pkg::LINK_CAP_RESET);
    end else if (cfg_we) begin
      cap_q <= RATE_BITS'(pwdata);
    end
  end

  // checks
  `MMFRA_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(FLOW_SLOTS), "active count overflow")
  `MMFRA_ASSERT_SAME(a_alloc_bound, state_q != S_IDLE, alloc_q <= cap_q, "capacity overrun")
  `MMFRA_ASSERT_SAME(a_live_rate, (state_q == S_SCAN) && live_q[idx_q], rate_q[idx_q] == '0, "live slot already has a rate")
  `MMFRA_ASSERT_SAME(a_div_state, div_done, state_q == S_DIV, "divider result outside wait state")
  `MMFRA_ASSERT_NEXT(a_report_run, out_valid_q && m_axis_tready && !out_last_q, out_valid_q, "gap in report run")

endmodule
